FILE: rtl/grhr_pkg.sv
// Shared types, constants and reset values for the golden-ratio hue to RGB block.
package grhr_pkg;

   localparam int HUE_BITS     = 24;
   localparam int CHANNEL_BITS = 16;

   // Shared multiplier operands: A carries a hue fraction or a channel value,
   // B carries a channel fraction that may reach exactly one.
   localparam int OPA_BITS  = ((HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS) + 1;
   localparam int OPB_BITS  = CHANNEL_BITS + 1;
   localparam int PROD_BITS = OPA_BITS + OPB_BITS;

   localparam int SECTOR_BITS = 3;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = (HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS;

   localparam logic [HUE_BITS:0]     HUE_ONE = {1'b1, {HUE_BITS{1'b0}}};
   localparam logic [CHANNEL_BITS:0] CH_ONE  = {1'b1, {CHANNEL_BITS{1'b0}}};

   // Golden-ratio conjugate in Q0.32, rounded to nearest at the hue width.
   localparam logic [63:0] GOLD_Q32 = 64'd2654435769;

   localparam logic [HUE_BITS-1:0] START_HUE_RESET = '0;
   localparam logic [HUE_BITS-1:0] HUE_STEP_RESET =
      HUE_BITS'((((GOLD_Q32 << 1) >> (32 - HUE_BITS)) + 64'd1) >> 1);
   localparam logic [CHANNEL_BITS-1:0] SATURATION_RESET =
      CHANNEL_BITS'(((64'd85 << CHANNEL_BITS) + 64'd50) / 64'd100);
   localparam logic [CHANNEL_BITS-1:0] VALUE_LEVEL_RESET =
      CHANNEL_BITS'(((64'd95 << CHANNEL_BITS) + 64'd50) / 64'd100);

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   localparam csr_index_type CSR_START_HUE   = 2'd0;
   localparam csr_index_type CSR_HUE_STEP    = 2'd1;
   localparam csr_index_type CSR_SATURATION  = 2'd2;
   localparam csr_index_type CSR_VALUE_LEVEL = 2'd3;

   typedef logic [SECTOR_BITS-1:0] sector_type;
   localparam sector_type SECTOR_RED_RISE_G  = 3'd0;
   localparam sector_type SECTOR_GREEN_TOP_R = 3'd1;
   localparam sector_type SECTOR_GREEN_TOP_B = 3'd2;
   localparam sector_type SECTOR_BLUE_TOP_G  = 3'd3;
   localparam sector_type SECTOR_BLUE_TOP_R  = 3'd4;
   localparam sector_type SECTOR_LAST        = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL_FS,
      ST_MUL_NFS,
      ST_MUL_P,
      ST_MUL_Q,
      ST_MUL_T,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      MUL_OP_FS,
      MUL_OP_NFS,
      MUL_OP_P,
      MUL_OP_Q,
      MUL_OP_T
   } mul_op_type;

   typedef struct packed {
      logic       req_ready;
      logic       prep;
      logic       mul_en;
      mul_op_type mul_op;
      logic       capture_fs;
      logic       capture_nfs;
      logic       capture_p;
      logic       capture_q;
      logic       finish;
   } ctrl_type;

endpackage

FILE: rtl/golden_ratio_hue_to_rgb.sv
// Top level: golden-ratio hue walker with fixed-point HSV to RGB conversion.
//
//   channel | ports                                      | direction
//   --------+--------------------------------------------+----------
//   req     | req_valid, req_stall, req_restart          | in
//   rsp     | rsp_valid, rsp_stall, rsp_red/green/blue   | out
//   csr     | csr_write_enable, csr_index, csr_write_data| in
//
// After a request word is accepted, a prep state splits hue*6 into sector
// and fraction, then five products go through the one shared multiplier,
// one per cycle, and a final state selects the channel assignment and
// loads the result. The request side stalls for that whole sequence, so a
// new word is not taken until the previous one is through. The result
// register holds a word while rsp_stall is high; the next request is taken
// the cycle after the result is loaded, and only the final select waits if
// the previous result is still unclaimed.
// Reset (synchronous) restores the configuration registers, sequencer and
// rsp_valid to their defaults and the hue phase to the reset start hue.
module golden_ratio_hue_to_rgb (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_restart,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [grhr_pkg::CHANNEL_BITS-1:0]   rsp_red,
   output logic [grhr_pkg::CHANNEL_BITS-1:0]   rsp_green,
   output logic [grhr_pkg::CHANNEL_BITS-1:0]   rsp_blue,
   input  logic                                csr_write_enable,
   input  grhr_pkg::csr_index_type             csr_index,
   input  logic [grhr_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   localparam int HB = grhr_pkg::HUE_BITS;
   localparam int CB = grhr_pkg::CHANNEL_BITS;

   grhr_pkg::ctrl_type ctrl;
   logic               accept;
   logic               out_busy;
   logic               load_rsp;

   // Configuration registers.
   logic [HB-1:0] start_hue_ff, start_hue_in;
   logic [HB-1:0] hue_step_ff, hue_step_in;
   logic [CB-1:0] saturation_ff, saturation_in;
   logic [CB-1:0] value_level_ff, value_level_in;

   // Hue state and per-word working registers.
   logic [HB-1:0]            phase_ff, phase_in;
   logic [HB+2:0]            hue_x6;
   grhr_pkg::sector_type     sector_ff;
   logic [HB-1:0]            frac_ff;
   logic [CB-1:0]            fs_ff, nfs_ff, p_ff, q_ff;

   logic [grhr_pkg::OPA_BITS-1:0]  operand_a;
   logic [grhr_pkg::OPB_BITS-1:0]  operand_b;
   logic [grhr_pkg::PROD_BITS-1:0] product;
   logic [CB-1:0]                  prod_hue_scaled;
   logic [CB-1:0]                  prod_ch_scaled;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [CB-1:0] red_ff, green_ff, blue_ff;
   logic [CB-1:0] red_in, green_in, blue_in;

   assign accept    = req_valid && ctrl.req_ready;
   assign req_stall = !ctrl.req_ready;
   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign load_rsp  = ctrl.finish && !out_busy;

   grhr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_busy  (out_busy),
      .ctrl      (ctrl)
   );

   // ---------------------------------------------------------------- config
   always_comb begin
      start_hue_in   = start_hue_ff;
      hue_step_in    = hue_step_ff;
      saturation_in  = saturation_ff;
      value_level_in = value_level_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            grhr_pkg::CSR_START_HUE:   start_hue_in   = csr_write_data[HB-1:0];
            grhr_pkg::CSR_HUE_STEP:    hue_step_in    = csr_write_data[HB-1:0];
            grhr_pkg::CSR_SATURATION:  saturation_in  = csr_write_data[CB-1:0];
            grhr_pkg::CSR_VALUE_LEVEL: value_level_in = csr_write_data[CB-1:0];
            default: ;
         endcase
      end
   end

   // A start hue write reloads the phase at once; a request advances it,
   // first reloading from the start register when restart is set.
   always_comb begin
      phase_in = phase_ff;
      if (csr_write_enable && (csr_index == grhr_pkg::CSR_START_HUE)) begin
         phase_in = csr_write_data[HB-1:0];
      end else if (accept) begin
         phase_in = (req_restart ? start_hue_ff : phase_ff) + hue_step_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_hue_ff   <= grhr_pkg::START_HUE_RESET;
         hue_step_ff    <= grhr_pkg::HUE_STEP_RESET;
         saturation_ff  <= grhr_pkg::SATURATION_RESET;
         value_level_ff <= grhr_pkg::VALUE_LEVEL_RESET;
         phase_ff       <= grhr_pkg::START_HUE_RESET;
      end else begin
         start_hue_ff   <= start_hue_in;
         hue_step_ff    <= hue_step_in;
         saturation_ff  <= saturation_in;
         value_level_ff <= value_level_in;
         phase_ff       <= phase_in;
      end
   end

   // ------------------------------------------------------------- datapath
   // hue * 6 as two shifted adds; the top bits are the sector.
   assign hue_x6 = ({3'b000, phase_ff} << 2) + ({3'b000, phase_ff} << 1);

   always_comb begin
      operand_a = '0;
      operand_b = '0;
      unique case (ctrl.mul_op)
         grhr_pkg::MUL_OP_FS: begin
            operand_a = grhr_pkg::OPA_BITS'(frac_ff);
            operand_b = grhr_pkg::OPB_BITS'(saturation_ff);
         end
         grhr_pkg::MUL_OP_NFS: begin
            operand_a = grhr_pkg::OPA_BITS'(grhr_pkg::HUE_ONE - {1'b0, frac_ff});
            operand_b = grhr_pkg::OPB_BITS'(saturation_ff);
         end
         grhr_pkg::MUL_OP_P: begin
            operand_a = grhr_pkg::OPA_BITS'(value_level_ff);
            operand_b = grhr_pkg::CH_ONE - {1'b0, saturation_ff};
         end
         grhr_pkg::MUL_OP_Q: begin
            operand_a = grhr_pkg::OPA_BITS'(value_level_ff);
            operand_b = grhr_pkg::CH_ONE - {1'b0, fs_ff};
         end
         grhr_pkg::MUL_OP_T: begin
            operand_a = grhr_pkg::OPA_BITS'(value_level_ff);
            operand_b = grhr_pkg::CH_ONE - {1'b0, nfs_ff};
         end
         default: ;
      endcase
   end

   grhr_mul_unit u_mul (
      .clock     (clock),
      .mul_en    (ctrl.mul_en),
      .operand_a (operand_a),
      .operand_b (operand_b),
      .product   (product)
   );

   // Truncate: fraction-by-saturation products drop the hue bits, the
   // value-scaled products drop the channel bits.
   assign prod_hue_scaled = product[HB +: CB];
   assign prod_ch_scaled  = product[CB +: CB];

   always_ff @(posedge clock) begin
      if (ctrl.prep) begin
         sector_ff <= hue_x6[HB +: grhr_pkg::SECTOR_BITS];
         frac_ff   <= hue_x6[HB-1:0];
      end
      if (ctrl.capture_fs) begin
         fs_ff <= prod_hue_scaled;
      end
      if (ctrl.capture_nfs) begin
         nfs_ff <= prod_hue_scaled;
      end
      if (ctrl.capture_p) begin
         p_ff <= prod_ch_scaled;
      end
      if (ctrl.capture_q) begin
         q_ff <= prod_ch_scaled;
      end
   end

   // ------------------------------------------------------- channel select
   // The t term comes straight off the multiplier in the finish cycle.
   always_comb begin
      unique case (sector_ff)
         grhr_pkg::SECTOR_RED_RISE_G: begin
            red_in = value_level_ff; green_in = prod_ch_scaled; blue_in = p_ff;
         end
         grhr_pkg::SECTOR_GREEN_TOP_R: begin
            red_in = q_ff; green_in = value_level_ff; blue_in = p_ff;
         end
         grhr_pkg::SECTOR_GREEN_TOP_B: begin
            red_in = p_ff; green_in = value_level_ff; blue_in = prod_ch_scaled;
         end
         grhr_pkg::SECTOR_BLUE_TOP_G: begin
            red_in = p_ff; green_in = q_ff; blue_in = value_level_ff;
         end
         grhr_pkg::SECTOR_BLUE_TOP_R: begin
            red_in = prod_ch_scaled; green_in = p_ff; blue_in = value_level_ff;
         end
         default: begin
            // last sector: red at full value, green at p, blue falling
            red_in = value_level_ff; green_in = p_ff; blue_in = q_ff;
         end
      endcase
   end

   // ------------------------------------------------------- result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

   // ------------------------------------------------------------ assertions
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("request side not stalled after accepting a word");

   a_sector_in_range: assert property (@(posedge clock) disable iff (reset)
      (ctrl.mul_en && ctrl.mul_op == grhr_pkg::MUL_OP_FS) |-> (sector_ff <= grhr_pkg::SECTOR_LAST))
      else $error("hue sector out of range");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> rsp_valid)
      else $error("result load did not raise rsp_valid");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !load_rsp)
      else $error("pending result overwritten");

endmodule

FILE: rtl/grhr_mul_unit.sv
// Shared unsigned multiplier with a registered product.
module grhr_mul_unit (
   input  logic                             clock,
   input  logic                             mul_en,
   input  logic [grhr_pkg::OPA_BITS-1:0]    operand_a,
   input  logic [grhr_pkg::OPB_BITS-1:0]    operand_b,
   output logic [grhr_pkg::PROD_BITS-1:0]   product
);

   logic [grhr_pkg::PROD_BITS-1:0] product_ff;
   logic [grhr_pkg::PROD_BITS-1:0] product_in;

   assign product_in = grhr_pkg::PROD_BITS'(operand_a) * grhr_pkg::PROD_BITS'(operand_b);

   // Hold the product until the next operation is issued.
   always_ff @(posedge clock) begin
      if (mul_en) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

FILE: rtl/grhr_ctrl.sv
// Sequencer that steps one word through the shared multiplier.
module grhr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              out_busy,
   output grhr_pkg::ctrl_type ctrl
);

   grhr_pkg::state_type state_ff;
   grhr_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= grhr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         grhr_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = grhr_pkg::ST_PREP;
            end
         end
         grhr_pkg::ST_PREP:    state_in = grhr_pkg::ST_MUL_FS;
         grhr_pkg::ST_MUL_FS:  state_in = grhr_pkg::ST_MUL_NFS;
         grhr_pkg::ST_MUL_NFS: state_in = grhr_pkg::ST_MUL_P;
         grhr_pkg::ST_MUL_P:   state_in = grhr_pkg::ST_MUL_Q;
         grhr_pkg::ST_MUL_Q:   state_in = grhr_pkg::ST_MUL_T;
         grhr_pkg::ST_MUL_T:   state_in = grhr_pkg::ST_FINISH;
         grhr_pkg::ST_FINISH: begin
            if (!out_busy) begin
               state_in = grhr_pkg::ST_IDLE;
            end
         end
         default: state_in = grhr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      ctrl.mul_op = grhr_pkg::MUL_OP_FS;
      unique case (state_ff)
         grhr_pkg::ST_IDLE: ctrl.req_ready = 1'b1;
         grhr_pkg::ST_PREP: ctrl.prep = 1'b1;
         grhr_pkg::ST_MUL_FS: begin
            ctrl.mul_en = 1'b1;
            ctrl.mul_op = grhr_pkg::MUL_OP_FS;
         end
         grhr_pkg::ST_MUL_NFS: begin
            ctrl.capture_fs = 1'b1;
            ctrl.mul_en     = 1'b1;
            ctrl.mul_op     = grhr_pkg::MUL_OP_NFS;
         end
         grhr_pkg::ST_MUL_P: begin
            ctrl.capture_nfs = 1'b1;
            ctrl.mul_en      = 1'b1;
            ctrl.mul_op      = grhr_pkg::MUL_OP_P;
         end
         grhr_pkg::ST_MUL_Q: begin
            ctrl.capture_p = 1'b1;
            ctrl.mul_en    = 1'b1;
            ctrl.mul_op    = grhr_pkg::MUL_OP_Q;
         end
         grhr_pkg::ST_MUL_T: begin
            ctrl.capture_q = 1'b1;
            ctrl.mul_en    = 1'b1;
            ctrl.mul_op    = grhr_pkg::MUL_OP_T;
         end
         grhr_pkg::ST_FINISH: ctrl.finish = 1'b1;
         default: ctrl = '0;
      endcase
   end

   a_finish_after_last_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == grhr_pkg::ST_FINISH) |->
         ($past(state_ff) == grhr_pkg::ST_MUL_T || $past(state_ff) == grhr_pkg::ST_FINISH))
      else $error("finish state entered without the last multiply");

   a_one_capture: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl.capture_fs, ctrl.capture_nfs, ctrl.capture_p, ctrl.capture_q,
                ctrl.finish, ctrl.prep}))
      else $error("more than one datapath capture in a cycle");

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the golden-ratio hue walker and HSV to RGB converter.
`timescale 1ns / 1ps

module tb_top;

   localparam int WATCHDOG_LIMIT = 4000;  // cycles without any handshake or register write
   localparam int SETTLE_CYCLES  = 20;    // idle cycles after the final drain before the verdict
   localparam int BLOCK_COUNT    = 12;
   localparam int BLOCK_WORDS    = 125;

   typedef struct packed {
      logic [grhr_pkg::CHANNEL_BITS-1:0] red;
      logic [grhr_pkg::CHANNEL_BITS-1:0] green;
      logic [grhr_pkg::CHANNEL_BITS-1:0] blue;
   } color_word_type;

   // Scoreboard: keeps its own copy of the registers and the hue phase, works
   // out the color for every accepted request and checks results in order.
   class color_scoreboard_type;
      logic [grhr_pkg::HUE_BITS-1:0]     start_hue;
      logic [grhr_pkg::HUE_BITS-1:0]     hue_step;
      logic [grhr_pkg::HUE_BITS-1:0]     hue_phase;
      logic [grhr_pkg::CHANNEL_BITS-1:0] saturation;
      logic [grhr_pkg::CHANNEL_BITS-1:0] value_level;
      color_word_type                    expected_colors[$];
      int                                errors;

      function new();
         start_hue   = '0;
         hue_step    = 24'd10368890;
         saturation  = 16'd55706;
         value_level = 16'd62259;
         hue_phase   = '0;
         errors      = 0;
      endfunction

      function int pending();
         return expected_colors.size();
      endfunction

      function void write_register(grhr_pkg::csr_index_type index,
                                   logic [grhr_pkg::CSR_DATA_BITS-1:0] data);
         case (index)
            grhr_pkg::CSR_START_HUE: begin
               start_hue = data[grhr_pkg::HUE_BITS-1:0];
               hue_phase = start_hue;
            end
            grhr_pkg::CSR_HUE_STEP:    hue_step    = data[grhr_pkg::HUE_BITS-1:0];
            grhr_pkg::CSR_SATURATION:  saturation  = data[grhr_pkg::CHANNEL_BITS-1:0];
            grhr_pkg::CSR_VALUE_LEVEL: value_level = data[grhr_pkg::CHANNEL_BITS-1:0];
            default: ;
         endcase
      endfunction

      function void note_request(logic restart);
         logic [63:0]          s, v, h6, f, fs, nfs, p, q, t;
         grhr_pkg::sector_type sector;
         color_word_type       color;
         s = 64'(saturation);
         v = 64'(value_level);
         if (restart) hue_phase = start_hue;
         hue_phase = hue_phase + hue_step;
         h6     = 64'(hue_phase) * 64'd6;
         sector = h6[grhr_pkg::HUE_BITS+2:grhr_pkg::HUE_BITS];
         f      = 64'(h6[grhr_pkg::HUE_BITS-1:0]);
         fs     = (f * s) >> grhr_pkg::HUE_BITS;
         nfs    = (((64'd1 << grhr_pkg::HUE_BITS) - f) * s) >> grhr_pkg::HUE_BITS;
         p      = (v * ((64'd1 << grhr_pkg::CHANNEL_BITS) - s)) >> grhr_pkg::CHANNEL_BITS;
         q      = (v * ((64'd1 << grhr_pkg::CHANNEL_BITS) - fs)) >> grhr_pkg::CHANNEL_BITS;
         t      = (v * ((64'd1 << grhr_pkg::CHANNEL_BITS) - nfs)) >> grhr_pkg::CHANNEL_BITS;
         case (sector)
            grhr_pkg::SECTOR_RED_RISE_G:  color = '{v[15:0], t[15:0], p[15:0]};
            grhr_pkg::SECTOR_GREEN_TOP_R: color = '{q[15:0], v[15:0], p[15:0]};
            grhr_pkg::SECTOR_GREEN_TOP_B: color = '{p[15:0], v[15:0], t[15:0]};
            grhr_pkg::SECTOR_BLUE_TOP_G:  color = '{p[15:0], q[15:0], v[15:0]};
            grhr_pkg::SECTOR_BLUE_TOP_R:  color = '{t[15:0], p[15:0], v[15:0]};
            default:                      color = '{v[15:0], p[15:0], q[15:0]};
         endcase
         expected_colors.push_back(color);
      endfunction

      function void check_color(color_word_type got);
         color_word_type want;
         if (expected_colors.size() == 0) begin
            $error("unexpected result word: red %0d green %0d blue %0d",
                   got.red, got.green, got.blue);
            errors++;
            return;
         end
         want = expected_colors.pop_front();
         if (got.red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, got.red);
            errors++;
         end
         if (got.green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, got.green);
            errors++;
         end
         if (got.blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, got.blue);
            errors++;
         end
      endfunction
   endclass

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic                               req_restart = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic [grhr_pkg::CHANNEL_BITS-1:0]  rsp_red;
   logic [grhr_pkg::CHANNEL_BITS-1:0]  rsp_green;
   logic [grhr_pkg::CHANNEL_BITS-1:0]  rsp_blue;
   logic                               csr_write_enable = 1'b0;
   grhr_pkg::csr_index_type            csr_index = grhr_pkg::CSR_START_HUE;
   logic [grhr_pkg::CSR_DATA_BITS-1:0] csr_write_data = '0;

   color_scoreboard_type color_check;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int quiet_cycles   = 0;

   golden_ratio_hue_to_rgb dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Sample both channels at the rising edge. Check results before noting the
   // new request: a result can never belong to a word accepted at that edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            color_check.check_color({rsp_red, rsp_green, rsp_blue});
         if (req_valid && !req_stall)
            color_check.note_request(req_restart);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable)
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stall the result side at random; the percentage follows the idling phase.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Abort when nothing has moved for too long.
   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("Simulation FAILED");
      $finish;
   end

   // Offer one request word and hold it until taken; return at a falling edge
   // with valid still high so back-to-back words need no extra assignment.
   task automatic send_color_word(input logic restart);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Drop valid and wait until every outstanding color has been returned.
   task automatic drain_colors();
      req_valid <= 1'b0;
      @(negedge clock);
      while (color_check.pending() != 0) @(negedge clock);
   endtask

   // Write one register; only called with the block idle.
   task automatic write_csr(input grhr_pkg::csr_index_type index,
                            input logic [grhr_pkg::CSR_DATA_BITS-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      color_check.write_register(index, data);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // Random register value: extremes a quarter of the time, full-width noise
   // otherwise so the discarded upper bits of narrow registers toggle too.
   function automatic logic [grhr_pkg::CSR_DATA_BITS-1:0] pick_csr_value();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return grhr_pkg::CSR_DATA_BITS'($urandom);
      endcase
   endfunction

   initial begin
      color_check = new();
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset defaults, continuing and restarting.
      send_color_word(1'b0);
      send_color_word(1'b0);
      send_color_word(1'b1);
      send_color_word(1'b0);
      drain_colors();

      // Zero step from a zero start: hue sits exactly at zero, fraction zero.
      write_csr(grhr_pkg::CSR_START_HUE, '0);
      write_csr(grhr_pkg::CSR_HUE_STEP, '0);
      write_csr(grhr_pkg::CSR_SATURATION, '1);
      write_csr(grhr_pkg::CSR_VALUE_LEVEL, '1);
      send_color_word(1'b1);
      send_color_word(1'b0);
      drain_colors();

      // Step of one sixth walks through every sector, sector five included,
      // and wraps past a full turn. Saturation write carries junk upper bits.
      write_csr(grhr_pkg::CSR_HUE_STEP, 24'd2796203);
      write_csr(grhr_pkg::CSR_SATURATION, 24'hAB8000);
      repeat (7) send_color_word(1'b0);
      drain_colors();

      // Maximum start and step: a write to start hue reloads the phase at once,
      // the step wraps; zero saturation and zero value.
      write_csr(grhr_pkg::CSR_START_HUE, '1);
      write_csr(grhr_pkg::CSR_HUE_STEP, '1);
      write_csr(grhr_pkg::CSR_SATURATION, '0);
      write_csr(grhr_pkg::CSR_VALUE_LEVEL, '0);
      send_color_word(1'b0);
      send_color_word(1'b1);
      send_color_word(1'b0);
      drain_colors();

      write_csr(grhr_pkg::CSR_SATURATION, '1);
      write_csr(grhr_pkg::CSR_VALUE_LEVEL, 24'd1);
      send_color_word(1'b0);
      send_color_word(1'b1);
      drain_colors();

      // Random blocks: cycle through the idling phases and reconfigure between
      // blocks; once per block pause the sender until everything is back.
      for (int block = 0; block < BLOCK_COUNT; block++) begin
         int pause_at;
         case (block % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
            default: begin send_idle_pct = 25; recv_stall_pct = 25; end
         endcase
         drain_colors();
         for (int index = 0; index < 4; index++)
            if ($urandom_range(2) != 0 || block == 0)
               write_csr(grhr_pkg::csr_index_type'(index), pick_csr_value());
         // Return the step to its golden default now and then.
         if ($urandom_range(3) == 0)
            write_csr(grhr_pkg::CSR_HUE_STEP, 24'd10368890);
         pause_at = $urandom_range(BLOCK_WORDS - 1);
         for (int word = 0; word < BLOCK_WORDS; word++) begin
            if (word == pause_at) drain_colors();
            send_color_word($urandom_range(7) == 0);
         end
      end

      drain_colors();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (color_check.errors == 0 && color_check.pending() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
